### rtl/achs_pkg.sv
// ----------------------------------------------------------------------------
// achs_pkg
// shared types and constants of the active channel hop selector: action codes,
// default channel plan and the sizing of the hop count reduction
// ----------------------------------------------------------------------------
package achs_pkg;

    typedef logic [1:0] action_t;

    localparam action_t ACT_WRITE    = 2'd0;
    localparam action_t ACT_DEFAULTS = 2'd1;
    localparam action_t ACT_STEP     = 2'd2;
    localparam action_t ACT_HOP      = 2'd3;

    localparam logic [31:0] DEFAULT_FREQ_0 = 32'd868100000;
    localparam logic [31:0] DEFAULT_FREQ_1 = 32'd868300000;
    localparam logic [31:0] DEFAULT_FREQ_2 = 32'd868500000;

    // widest table index over the supported range of channel counts
    localparam int INDEX_W_MAX = 6;

    // width of the random value fed to the hop count reduction
    localparam int RND_W       = 32;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MOD  = 6'b000010,
        S_REM  = 6'b000100,
        S_STEP = 6'b001000,
        S_READ = 6'b010000,
        S_RESP = 6'b100000
    } state_t;

    function automatic logic [31:0] default_freq(input logic [INDEX_W_MAX-1:0] idx);
        logic [31:0] f;
        unique case (idx)
            6'd0:    f = DEFAULT_FREQ_0;
            6'd1:    f = DEFAULT_FREQ_1;
            6'd2:    f = DEFAULT_FREQ_2;
            default: f = 32'd0;
        endcase
        return f;
    endfunction

endpackage

### rtl/active_channel_hop_selector.sv
// ----------------------------------------------------------------------------
// active_channel_hop_selector
// channel table with next-active and random hop selection
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one action: write a table entry,
// restore the default plan, step to the next active channel, or hop a number
// of steps given by random_value mod CHANNELS. Every input transfer yields
// exactly one output transfer (out_valid / out_stall) with the selected index,
// its frequency and the number of active entries.
// The frequency table sits in a memory with a registered read; a
// per-entry valid flag makes unwritten entries read as the default plan.
// Write and restore go through the read and response states; a step moves the
// index to the next entry until it lands on an active one (1 to CHANNELS+1 moves);
// a hop first reduces random_value modulo CHANNELS (reciprocal multiply, then one
// correction) and then takes that many steps; a remainder of zero takes none.
// One item is processed at a time; the input stalls while an item is in work.
// A finished result waits in the output register while the next item is taken.
// Reset restores the default plan and selects index 0 at once, no sweep.
// While the receiver stalls, the output holds and a newer result waits inside.
// ----------------------------------------------------------------------------
module active_channel_hop_selector #(
    parameter int CHANNELS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  achs_pkg::action_t    action,
    input  logic [3:0]           channel_index,
    input  logic [31:0]          frequency,
    input  logic [31:0]          random_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [3:0]           current_index,
    output logic [31:0]          current_frequency,
    output logic [4:0]           active_count
);
    import achs_pkg::*;

    localparam int IW = $clog2(CHANNELS);
    localparam int CW = $clog2(CHANNELS + 1);
    localparam logic [IW-1:0]       LAST_INDEX     = IW'(CHANNELS - 1);
    localparam logic [IW:0]         MOD_DIVISOR    = (IW + 1)'(CHANNELS);
    localparam logic [CHANNELS-1:0] DEFAULT_ACTIVE = CHANNELS'(3'b111);

    // floor(2^shift / CHANNELS) gives a quotient that is exact or one low
    localparam int                  RECIP_SHIFT    = RND_W + IW;
    localparam logic [32:0]         RECIP          = 33'((64'd1 << RECIP_SHIFT) /
                                                         64'(CHANNELS));
    localparam int                  PROD_W         = RND_W + 33;

    state_t                 state_reg, state_next;
    logic [IW-1:0]          sel_reg, sel_next;
    logic [CW-1:0]          moves_reg, moves_next;
    logic [IW-1:0]          hops_reg, hops_next;
    logic [RND_W-1:0]       rnd_reg, rnd_next;
    logic [RND_W-1:0]       quot_reg, quot_next;
    logic [CHANNELS-1:0]    valid_reg, valid_next;
    logic [CHANNELS-1:0]    active_reg, active_next;
    logic [CW-1:0]          count_reg, count_next;

    logic                   out_valid_reg, out_valid_next;
    logic [3:0]             out_index_reg, out_index_next;
    logic [31:0]            out_freq_reg, out_freq_next;
    logic [4:0]             out_count_reg, out_count_next;

    // frequency memory
    logic [31:0]            mem [CHANNELS];
    logic                   mem_we;
    logic [IW-1:0]          wr_addr;
    logic [31:0]            rd_data_reg;
    logic                   rd_valid_reg;

    logic [IW-1:0]          next_sel;
    logic [PROD_W-1:0]      recip_prod;
    logic [IW:0]            quot_low;
    logic [IW:0]            rem_try;
    logic [IW-1:0]          mod_rem;
    logic [7:0]             count_ext;
    logic [7:0]             index_ext;

    assign wr_addr  = IW'(channel_index);
    assign next_sel = (sel_reg == LAST_INDEX) ? '0 : sel_reg + 1'b1;
    assign in_stall = (state_reg != S_IDLE);

    assign out_valid         = out_valid_reg;
    assign current_index     = out_index_reg;
    assign current_frequency = out_freq_reg;
    assign active_count      = out_count_reg;

    // reciprocal multiply for the quotient estimate
    assign recip_prod = PROD_W'(rnd_reg) * PROD_W'(RECIP);

    // remainder is below 2*CHANNELS, so the low bits are enough
    assign quot_low = quot_reg[IW:0] * MOD_DIVISOR;
    assign rem_try  = rnd_reg[IW:0] - quot_low;
    assign mod_rem  = (rem_try >= MOD_DIVISOR) ? IW'(rem_try - MOD_DIVISOR)
                                               : rem_try[IW-1:0];

    assign count_ext = 8'(count_reg);
    assign index_ext = 8'(sel_reg);

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        moves_next     = moves_reg;
        hops_next      = hops_reg;
        rnd_next       = rnd_reg;
        quot_next      = quot_reg;
        valid_next     = valid_reg;
        active_next    = active_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_freq_next  = out_freq_reg;
        out_count_next = out_count_reg;
        mem_we         = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action)
                        ACT_WRITE:
                        begin
                            if (32'(channel_index) < CHANNELS)
                            begin
                                mem_we               = 1'b1;
                                valid_next[wr_addr]  = 1'b1;
                                active_next[wr_addr] = (frequency != 32'd0);
                                if (active_reg[wr_addr] && frequency == 32'd0)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                                else if (!active_reg[wr_addr] && frequency != 32'd0)
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            state_next = S_READ;
                        end
                        ACT_DEFAULTS:
                        begin
                            valid_next  = '0;
                            active_next = DEFAULT_ACTIVE;
                            count_next  = CW'(3);
                            sel_next    = '0;
                            state_next  = S_READ;
                        end
                        ACT_STEP:
                        begin
                            sel_next   = next_sel;
                            moves_next = '0;
                            hops_next  = IW'(1);
                            state_next = S_STEP;
                        end
                        ACT_HOP:
                        begin
                            rnd_next   = random_value;
                            state_next = S_MOD;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                quot_next  = RND_W'(recip_prod >> RECIP_SHIFT);
                state_next = S_REM;
            end
            S_REM:
            begin
                if (mod_rem == '0)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    hops_next  = mod_rem;
                    sel_next   = next_sel;
                    moves_next = '0;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                // one index move per cycle; a step ends on an active entry
                // or after a full extra lap
                if (active_reg[sel_reg] || moves_reg == CW'(CHANNELS))
                begin
                    hops_next = hops_reg - 1'b1;
                    if (hops_reg == IW'(1))
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        sel_next   = next_sel;
                        moves_next = '0;
                    end
                end
                else
                begin
                    sel_next   = next_sel;
                    moves_next = moves_reg + 1'b1;
                end
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = index_ext[3:0];
                    out_freq_next  = rd_valid_reg ? rd_data_reg
                                                  : default_freq(INDEX_W_MAX'(sel_reg));
                    out_count_next = (count_ext > 8'd31) ? 5'd31 : count_ext[4:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= '0;
            moves_reg     <= '0;
            hops_reg      <= '0;
            valid_reg     <= '0;
            active_reg    <= DEFAULT_ACTIVE;
            count_reg     <= CW'(3);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            moves_reg     <= moves_next;
            hops_reg      <= hops_next;
            valid_reg     <= valid_next;
            active_reg    <= active_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg       <= rnd_next;
        quot_reg      <= quot_next;
        out_index_reg <= out_index_next;
        out_freq_reg  <= out_freq_next;
        out_count_reg <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= frequency;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg  <= mem[sel_reg];
            rd_valid_reg <= valid_reg[sel_reg];
        end
    end

endmodule
